### design/gfg_pkg.sv
// ----------------------------------------------------------------------------
// gfg_pkg
// Shared constants, types and helpers for the grid field gradient block.
// ----------------------------------------------------------------------------
package gfg_pkg;

  localparam int GRID_DIM  = 65;
  localparam int CELLS     = GRID_DIM * GRID_DIM;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int IDX_W     = 7;
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC      = 16;
  localparam int RMAG_W    = PROD_W - FRAC;
  localparam int S_W       = RMAG_W + 1;
  localparam int E_W       = S_W + 2;

  localparam int CQ_DEPTH  = 4;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam logic [DATA_W-1:0] INV_RESET = DATA_W'(32768);

  typedef enum logic {
    OP_WRITE,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_INNER,
    MODE_EXT_X,
    MODE_EXT_Y
  } mode_t;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    op_t               op;
    mode_t             mode;
    addr_t [3:0]       addr;
    logic [DATA_W-1:0] wdata;
  } job_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] step;
    mode_t      mode;
  } rtag_t;

  typedef struct packed {
    logic  vld;
    logic  sel;
    mode_t mode;
  } tok_t;

  typedef struct packed {
    logic [DATA_W-1:0] fx;
    logic [DATA_W-1:0] fy;
  } result_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [E_W-1:0] v);
    logic fits;
    fits = (&v[E_W-1:DATA_W-1]) | ~(|v[E_W-1:DATA_W-1]);
    if (fits) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[E_W-1]) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

### design/gfg_ram.sv
// ----------------------------------------------------------------------------
// gfg_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/gfg_front.sv
// ----------------------------------------------------------------------------
// gfg_front
// Accepts commands, classifies the cell, works out the grid addresses and
// queues the resulting job for the back end.
// ----------------------------------------------------------------------------
module gfg_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_cmd,
  input  logic [gfg_pkg::IDX_W-1:0]        in_row,
  input  logic [gfg_pkg::IDX_W-1:0]        in_col,
  input  logic signed [gfg_pkg::DATA_W-1:0] in_potential,
  output gfg_pkg::job_t                    job,
  output logic                             job_vld,
  input  logic                             job_pop
);

  localparam int D = gfg_pkg::GRID_DIM;

  logic                           on_grid;
  logic                           row_first, row_last, col_first, col_last;
  gfg_pkg::addr_t                 base;
  int                             off [4];
  gfg_pkg::job_t                  job_new;
  logic                           keep;
  logic                           push_acc;

  gfg_pkg::job_t                  q_r [gfg_pkg::CQ_DEPTH];
  logic [gfg_pkg::CQ_PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [gfg_pkg::CQ_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [gfg_pkg::CQ_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    on_grid   = (32'(in_row) < 32'(D)) && (32'(in_col) < 32'(D));
    row_first = in_row == '0;
    col_first = in_col == '0;
    row_last  = 32'(in_row) == 32'(D - 1);
    col_last  = 32'(in_col) == 32'(D - 1);
    base      = gfg_pkg::ADDR_W'(32'(in_row) * 32'(D) + 32'(in_col));

    job_new.op    = in_cmd ? gfg_pkg::OP_READ : gfg_pkg::OP_WRITE;
    job_new.wdata = in_potential;
    job_new.mode  = gfg_pkg::MODE_ZERO;
    off[0] = 0;
    off[1] = 0;
    off[2] = 0;
    off[3] = 0;

    if (!on_grid || ((row_first || row_last) && (col_first || col_last))) begin
      job_new.mode = gfg_pkg::MODE_ZERO;
    end else if (row_first) begin
      job_new.mode = gfg_pkg::MODE_EXT_Y;
      off[0] = 0;      off[1] = 2 * D;
      off[2] = D;      off[3] = 3 * D;
    end else if (row_last) begin
      job_new.mode = gfg_pkg::MODE_EXT_Y;
      off[0] = -2 * D; off[1] = 0;
      off[2] = -3 * D; off[3] = -D;
    end else if (col_first) begin
      job_new.mode = gfg_pkg::MODE_EXT_X;
      off[0] = 0;      off[1] = 2;
      off[2] = 1;      off[3] = 3;
    end else if (col_last) begin
      job_new.mode = gfg_pkg::MODE_EXT_X;
      off[0] = -2;     off[1] = 0;
      off[2] = -3;     off[3] = -1;
    end else begin
      job_new.mode = gfg_pkg::MODE_INNER;
      off[0] = -1;     off[1] = 1;
      off[2] = -D;     off[3] = D;
    end

    if (job_new.op == gfg_pkg::OP_WRITE) begin
      job_new.mode = gfg_pkg::MODE_ZERO;
      off[0] = 0;
    end

    for (int i = 0; i < 4; i++) begin
      job_new.addr[i] = gfg_pkg::ADDR_W'(int'(base) + off[i]);
    end
  end

  // drop writes outside the grid
  assign keep     = on_grid || (job_new.op == gfg_pkg::OP_READ);
  assign in_full  = cnt_r == gfg_pkg::CQ_CNT_W'(gfg_pkg::CQ_DEPTH);
  assign push_acc = in_push && !in_full && keep;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_acc) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (job_pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push_acc && !job_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_acc && job_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      q_r[wptr_r] <= job_new;
    end
  end

  assign job     = q_r[rptr_r];
  assign job_vld = cnt_r != '0;

endmodule

### design/gfg_calc.sv
// ----------------------------------------------------------------------------
// gfg_calc
// Scales each neighbour difference by the configured reciprocal, rounds to
// Q16.16, then forms the central or extrapolated components and saturates.
// ----------------------------------------------------------------------------
module gfg_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gfg_pkg::tok_t                     tok_in,
  input  logic signed [gfg_pkg::DIFF_W-1:0] diff_in,
  input  logic [gfg_pkg::DATA_W-1:0]        inv,
  output logic                              res_vld,
  output gfg_pkg::result_t                  res
);

  localparam logic [gfg_pkg::PROD_W-1:0] RND_HALF =
    gfg_pkg::PROD_W'(1) << (gfg_pkg::FRAC - 1);

  gfg_pkg::tok_t                     t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [gfg_pkg::DIFF_W-1:0] dif_r;
  logic [gfg_pkg::DIFF_W-1:0]        mag_r, mag_nxt;
  logic                              neg2_r, neg3_r, neg4_r;
  logic [gfg_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic                              hi3_r;
  logic [gfg_pkg::PROD_W-1:0]        pm, psum;
  logic [gfg_pkg::RMAG_W-1:0]        rmag_r;
  logic signed [gfg_pkg::S_W-1:0]    s_r, s_nxt, s0_r;
  logic signed [gfg_pkg::E_W-1:0]    e0, e1, ext;

  always_comb begin
    mag_nxt  = dif_r[gfg_pkg::DIFF_W-1] ? gfg_pkg::DIFF_W'(-dif_r)
                                        : gfg_pkg::DIFF_W'(dif_r);
    prod_nxt = mag_r[gfg_pkg::DATA_W-1:0] * inv;
    // a magnitude of exactly 2^32 leaves the low word zero
    pm       = hi3_r ? {inv, {gfg_pkg::DATA_W{1'b0}}} : prod_r;
    psum     = pm + RND_HALF;
    s_nxt    = neg4_r ? -$signed({1'b0, rmag_r}) : $signed({1'b0, rmag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
      t5_r <= '0;
    end else begin
      t1_r <= tok_in;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
    end
  end

  always_ff @(posedge clk) begin
    dif_r  <= diff_in;
    mag_r  <= mag_nxt;
    neg2_r <= dif_r[gfg_pkg::DIFF_W-1];
    prod_r <= prod_nxt;
    hi3_r  <= mag_r[gfg_pkg::DATA_W];
    neg3_r <= neg2_r;
    rmag_r <= psum[gfg_pkg::PROD_W-1:gfg_pkg::FRAC];
    neg4_r <= neg3_r;
    s_r    <= s_nxt;
    if (t5_r.vld && !t5_r.sel) begin
      s0_r <= s_r;
    end
  end

  always_comb begin
    e0      = gfg_pkg::E_W'(s0_r);
    e1      = gfg_pkg::E_W'(s_r);
    ext     = (e0 <<< 1) - e1;
    res_vld = t5_r.vld && t5_r.sel;
    unique case (t5_r.mode)
      gfg_pkg::MODE_INNER: begin
        res.fx = gfg_pkg::sat32(e0);
        res.fy = gfg_pkg::sat32(e1);
      end
      gfg_pkg::MODE_EXT_X: begin
        res.fx = gfg_pkg::sat32(ext);
        res.fy = '0;
      end
      gfg_pkg::MODE_EXT_Y: begin
        res.fx = '0;
        res.fy = gfg_pkg::sat32(ext);
      end
      default: begin
        res.fx = '0;
        res.fy = '0;
      end
    endcase
  end

endmodule

### design/gfg_back.sv
// ----------------------------------------------------------------------------
// gfg_back
// Runs queued jobs against the grid memory: one write per cycle, or up to
// four sample reads per field request, then the arithmetic and result queue.
// ----------------------------------------------------------------------------
module gfg_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gfg_pkg::job_t                      job,
  input  logic                               job_vld,
  output logic                               job_pop,
  input  logic [gfg_pkg::DATA_W-1:0]         inv,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [gfg_pkg::DATA_W-1:0]  out_field_x,
  output logic signed [gfg_pkg::DATA_W-1:0]  out_field_y
);

  logic [1:0]                        step_r, step_nxt;
  logic                              credit;
  logic                              launch;
  logic                              ram_we, ram_re;
  gfg_pkg::addr_t                    ram_addr;
  logic [gfg_pkg::DATA_W-1:0]        ram_rdata;
  gfg_pkg::rtag_t                    issue, lat_r;
  logic signed [gfg_pkg::DATA_W-1:0] a_r;
  gfg_pkg::tok_t                     tok;
  logic signed [gfg_pkg::DIFF_W-1:0] diff;
  logic                              res_vld;
  gfg_pkg::result_t                  res;

  gfg_pkg::result_t                  oq_r [gfg_pkg::OQ_DEPTH];
  logic [gfg_pkg::OQ_PTR_W-1:0]      owptr_r, orptr_r;
  logic [gfg_pkg::OQ_CNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic [gfg_pkg::OQ_CNT_W-1:0]      pend_r, pend_nxt;
  logic                              pop_acc;

  assign credit = pend_r < gfg_pkg::OQ_CNT_W'(gfg_pkg::OQ_DEPTH);

  always_comb begin
    step_nxt   = step_r;
    job_pop    = 1'b0;
    launch     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = job.addr[step_r];
    issue.vld  = 1'b0;
    issue.step = step_r;
    issue.mode = job.mode;
    if (job_vld) begin
      if (job.op == gfg_pkg::OP_WRITE) begin
        ram_we   = 1'b1;
        ram_addr = job.addr[0];
        job_pop  = 1'b1;
      end else if ((step_r != 2'd0) || credit) begin
        launch    = step_r == 2'd0;
        issue.vld = 1'b1;
        if (job.mode == gfg_pkg::MODE_ZERO) begin
          // no samples needed: send one closing token straight through
          issue.step = 2'd3;
          job_pop    = 1'b1;
        end else begin
          ram_re = 1'b1;
          if (step_r == 2'd3) begin
            job_pop  = 1'b1;
            step_nxt = 2'd0;
          end else begin
            step_nxt = step_r + 2'd1;
          end
        end
      end
    end
  end

  gfg_ram #(
    .WIDTH (gfg_pkg::DATA_W),
    .DEPTH (gfg_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (job.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (lat_r.vld && !lat_r.step[0]) begin
      a_r <= $signed(ram_rdata);
    end
  end

  always_comb begin
    tok.vld  = lat_r.vld && lat_r.step[0];
    tok.sel  = lat_r.step[1];
    tok.mode = lat_r.mode;
    diff     = gfg_pkg::DIFF_W'(a_r) - gfg_pkg::DIFF_W'($signed(ram_rdata));
  end

  gfg_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .tok_in  (tok),
    .diff_in (diff),
    .inv     (inv),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_empty = ocnt_r == '0;
  assign pop_acc   = out_pop && !out_empty;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_vld && !pop_acc) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!res_vld && pop_acc) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
    pend_nxt = pend_r;
    if (launch && !pop_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!launch && pop_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      lat_r   <= '0;
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
      pend_r  <= '0;
    end else begin
      step_r <= step_nxt;
      lat_r  <= issue;
      ocnt_r <= ocnt_nxt;
      pend_r <= pend_nxt;
      if (res_vld) begin
        owptr_r <= owptr_r + 1'b1;
      end
      if (pop_acc) begin
        orptr_r <= orptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      oq_r[owptr_r] <= res;
    end
  end

  assign out_field_x = $signed(oq_r[orptr_r].fx);
  assign out_field_y = $signed(oq_r[orptr_r].fy);

endmodule

### design/grid_field_gradient.sv
// ----------------------------------------------------------------------------
// grid_field_gradient
// Field components from a stored square grid of Q16.16 potential samples.
//
// Commands enter through push/full: cmd 0 stores a sample at (row, col),
// cmd 1 requests the two field components at (row, col). Results leave
// through empty/pop, oldest first, one per request and none per store.
// The cfg channel (valid/ready, always ready) loads the reciprocal of twice
// the grid spacing; load it only while no request is outstanding.
// A store makes one write to the single-port grid memory; a request reads
// its up to four neighbouring samples one per cycle, or none when the cell
// needs no samples (corners, off-grid cells). A request holds the memory
// until its samples are read, and stores sustain one per cycle while no
// request holds it. A four-entry command queue decouples intake from the
// memory sequencer, and an eight-entry result queue absorbs a stalled
// receiver; when it is committed full, requests wait and full rises once
// the command queue fills. Reset empties both queues and restores the
// spacing register; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module grid_field_gradient (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_cmd,
  input  logic [gfg_pkg::IDX_W-1:0]          in_row,
  input  logic [gfg_pkg::IDX_W-1:0]          in_col,
  input  logic signed [gfg_pkg::DATA_W-1:0]  in_potential,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [gfg_pkg::DATA_W-1:0]  out_field_x,
  output logic signed [gfg_pkg::DATA_W-1:0]  out_field_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gfg_pkg::DATA_W-1:0]         cfg_inv_two_spacing
);

  logic [gfg_pkg::DATA_W-1:0] inv_r;
  gfg_pkg::job_t              job;
  logic                       job_vld;
  logic                       job_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= gfg_pkg::INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_r <= cfg_inv_two_spacing;
    end
  end

  gfg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_potential (in_potential),
    .job          (job),
    .job_vld      (job_vld),
    .job_pop      (job_pop)
  );

  gfg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (job),
    .job_vld     (job_vld),
    .job_pop     (job_pop),
    .inv         (inv_r),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_field_x (out_field_x),
    .out_field_y (out_field_y)
  );

endmodule
